[hw/rtl/imubrs_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the IMU burst-read sequencer.
package imubrs_pkg;

    localparam int unsigned FRAME_LEN = 14;
    localparam int unsigned NACK_FROM = 13;
    localparam int unsigned NUM_WORDS = FRAME_LEN / 2;
    localparam int unsigned CNT_W     = 4;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_W     = 8;

    localparam logic [6:0] DEV_ADDR_RST  = 7'd104;
    localparam logic [7:0] FIRST_REG_RST = 8'd59;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEVICE_ADDRESS = 1'b0,
        CFG_FIRST_REGISTER = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        OP_BEGIN      = 2'd0,
        OP_START_SENT = 2'd1,
        OP_ADDR_ACK   = 2'd2,
        OP_BYTE_DONE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ACT_NONE        = 3'd0,
        ACT_START       = 3'd1,
        ACT_ADDR_W      = 3'd2,
        ACT_INDEX       = 3'd3,
        ACT_ADDR_R      = 3'd4,
        ACT_STORED      = 3'd5,
        ACT_STORED_STOP = 3'd6
    } t_action;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ADDR_W  = 3'd1,
        PH_INDEX   = 3'd2,
        PH_RESTART = 3'd3,
        PH_ADDR_R  = 3'd4,
        PH_DATA    = 3'd5
    } t_phase;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] rx_byte;
    } t_in;

    typedef struct packed {
        logic [2:0]         action;
        logic [7:0]         tx_byte;
        logic               sample_valid;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] temperature;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
    } t_out;

    typedef struct packed {
        logic             we;
        logic [CNT_W-1:0] idx;
        logic             last;
    } t_store_ctl;

endpackage

[hw/rtl/imubrs_fsm.sv]
`timescale 1ns / 1ps
// Phase sequencer, byte counter and configuration registers.
module imubrs_fsm (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_evt_en,
    input  imubrs_pkg::t_in                     i_evt,
    input  logic                                i_cfg_we,
    input  logic [imubrs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [imubrs_pkg::CFG_W-1:0]        i_cfg_data,
    output logic [2:0]                          o_action,
    output logic [7:0]                          o_tx_byte,
    output imubrs_pkg::t_store_ctl              o_store
);
    import imubrs_pkg::*;

    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [6:0]       r_dev_addr;
    logic [7:0]       r_first_reg;
    t_action          action;
    logic             last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr  <= DEV_ADDR_RST;
            r_first_reg <= FIRST_REG_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_DEVICE_ADDRESS: r_dev_addr  <= i_cfg_data[6:0];
                CFG_FIRST_REGISTER: r_first_reg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= '0;
        end else if (i_evt_en) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        action    = ACT_NONE;
        o_tx_byte = 8'd0;
        last      = (r_cnt == CNT_W'(FRAME_LEN - 1));
        o_store   = '{we: 1'b0, idx: r_cnt, last: 1'b0};
        unique case (t_op'(i_evt.operation))
            OP_BEGIN: begin
                if (r_phase == PH_IDLE) action = ACT_START;
            end
            OP_START_SENT: begin
                priority if (r_phase == PH_IDLE) begin
                    action    = ACT_ADDR_W;
                    o_tx_byte = {r_dev_addr, 1'b0};
                    n_phase   = PH_ADDR_W;
                end else if (r_phase == PH_RESTART) begin
                    action    = ACT_ADDR_R;
                    o_tx_byte = {r_dev_addr, 1'b1};
                    n_phase   = PH_ADDR_R;
                end else begin
                end
            end
            OP_ADDR_ACK: begin
                priority if (r_phase == PH_ADDR_W) begin
                    action    = ACT_INDEX;
                    o_tx_byte = r_first_reg;
                    n_phase   = PH_INDEX;
                end else if (r_phase == PH_ADDR_R) begin
                    n_cnt   = '0;
                    n_phase = PH_DATA;
                end else begin
                end
            end
            OP_BYTE_DONE: begin
                priority if (r_phase == PH_INDEX) begin
                    action  = ACT_START;
                    n_phase = PH_RESTART;
                end else if (r_phase == PH_DATA) begin
                    o_store.we   = 1'b1;
                    o_store.last = last;
                    action = (r_cnt >= CNT_W'(NACK_FROM - 1)) ? ACT_STORED_STOP : ACT_STORED;
                    if (last) begin
                        n_cnt   = '0;
                        n_phase = PH_IDLE;
                    end else begin
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                end else begin
                end
            end
            default: ;
        endcase
        o_action = action;
    end

endmodule

[hw/rtl/imubrs_frame.sv]
`timescale 1ns / 1ps
// Frame byte store and big-endian word assembly.
module imubrs_frame (
    input  logic                   i_clk,
    input  logic                   i_evt_en,
    input  logic [7:0]             i_rx_byte,
    input  imubrs_pkg::t_store_ctl i_store,
    output logic [15:0]            o_words [imubrs_pkg::NUM_WORDS]
);
    import imubrs_pkg::*;

    logic [7:0] r_bytes [FRAME_LEN];
    logic [7:0] cur     [FRAME_LEN];

    always_ff @(posedge i_clk) begin
        if (i_evt_en && i_store.we && (i_store.idx < CNT_W'(FRAME_LEN))) begin
            r_bytes[i_store.idx] <= i_rx_byte;
        end
    end

    always_comb begin
        for (int k = 0; k < FRAME_LEN - 1; k++) cur[k] = r_bytes[k];
        cur[FRAME_LEN-1] = i_rx_byte;
        for (int j = 0; j < NUM_WORDS; j++) begin
            o_words[j] = i_store.last ? {cur[2*j], cur[2*j+1]} : 16'd0;
        end
    end

endmodule

[hw/rtl/imubrs_out_buf.sv]
`timescale 1ns / 1ps
// Result register with skid stage on the output channel.
module imubrs_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  imubrs_pkg::t_out  i_res,
    output logic              o_space,
    output logic              o_valid,
    input  logic              i_ready,
    output imubrs_pkg::t_out  o_data
);
    import imubrs_pkg::*;

    logic r_o_vld, r_s_vld;
    t_out r_o, r_s;
    logic pop;

    assign pop     = r_o_vld && i_ready;
    assign o_space = !r_s_vld;
    assign o_valid = r_o_vld;
    assign o_data  = r_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
            r_s_vld <= 1'b0;
        end else if (pop) begin
            if (r_s_vld) begin
                r_s_vld <= 1'b0;
            end else begin
                r_o_vld <= i_push;
            end
        end else if (!r_o_vld) begin
            r_o_vld <= i_push;
        end else if (i_push) begin
            r_s_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_o <= r_s_vld ? r_s : i_res;
        end else if (!r_o_vld) begin
            r_o <= i_res;
        end else if (i_push) begin
            r_s <= i_res;
        end
    end

endmodule

[hw/rtl/imu_burst_read_sequencer_top.sv]
`timescale 1ns / 1ps
// Top level of the IMU burst-read sequencer.
//
//  channel   signals                          width          direction
//  event     i_valid / o_ready / i_data       t_in  (10)     in
//  result    o_valid / i_ready / o_data       t_out (124)    out
//  config    i_cfg_we / i_cfg_idx / i_cfg_data 1 + 1 + 8     in
//
// One event is taken per cycle while o_ready is high; its result is registered on acceptance.
// Phase and byte count update at the accept edge; the 14-entry byte store is write-only
// per event and read as a whole on the last data byte.
// Reset clears phase, count, config to defaults and the output stages.
// A stalled result sits in the output register; one more event fits in the skid stage.
module imu_burst_read_sequencer_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  imubrs_pkg::t_in                   i_data,
    output logic                              o_valid,
    input  logic                              i_ready,
    output imubrs_pkg::t_out                  o_data,
    input  logic                              i_cfg_we,
    input  logic [imubrs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [imubrs_pkg::CFG_W-1:0]      i_cfg_data
);
    import imubrs_pkg::*;

    logic       evt_en;
    logic [2:0] action;
    logic [7:0] tx_byte;
    t_store_ctl store;
    logic [15:0] words [NUM_WORDS];
    t_out       res;

    assign evt_en = i_valid && o_ready;

    imubrs_fsm u_fsm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_evt_en   (evt_en),
        .i_evt      (i_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_action   (action),
        .o_tx_byte  (tx_byte),
        .o_store    (store)
    );

    imubrs_frame u_frame (
        .i_clk     (i_clk),
        .i_evt_en  (evt_en),
        .i_rx_byte (i_data.rx_byte),
        .i_store   (store),
        .o_words   (words)
    );

    always_comb begin
        res.action       = action;
        res.tx_byte      = tx_byte;
        res.sample_valid = store.last;
        res.accel_x      = words[0];
        res.accel_y      = words[1];
        res.accel_z      = words[2];
        res.temperature  = words[3];
        res.gyro_x       = words[4];
        res.gyro_y       = words[5];
        res.gyro_z       = words[6];
    end

    imubrs_out_buf u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (evt_en),
        .i_res   (res),
        .o_space (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    a_ready_implies_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("skid stage holds a transaction while output register is empty");

    a_sample_has_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.sample_valid) |-> (o_data.action == ACT_STORED_STOP))
        else $error("frame completed without nack and stop action");

    a_tx_only_on_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.tx_byte != 8'd0) |->
        (o_data.action == ACT_ADDR_W || o_data.action == ACT_ADDR_R
         || o_data.action == ACT_INDEX))
        else $error("transmit byte set on a non-transmit action");

    a_last_resets_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (evt_en && store.last) |=> (u_fsm.r_phase == PH_IDLE))
        else $error("phase not idle after last frame byte");

endmodule

[bench/imu_burst_read_sequencer_top_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the IMU burst-read sequencer top level.
module imu_burst_read_sequencer_top_tb;
    import imubrs_pkg::*;

    localparam int unsigned TARGET_EVENTS = 1525;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned STALL_LIMIT   = 2000;
    localparam int unsigned DRAIN_CYCLES  = 8;
    localparam int unsigned MAX_PRINTED   = 200;
    localparam int unsigned SEQ_LEN       = 6 + FRAME_LEN;

    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic                 ev_valid  = 1'b0;
    t_in                  ev_data   = '0;
    logic                 o_ready;
    logic                 o_valid;
    logic                 res_ready = 1'b0;
    t_out                 o_data;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = CFG_DEVICE_ADDRESS;
    logic [CFG_W-1:0]     cfg_data  = '0;

    t_in  queued_events[$];
    t_out pending_results[$];
    int   events_queued  = 0;
    int   mismatch_count = 0;
    int   ev_gap         = 0;
    int   ev_max_gap     = 5;
    bit   ev_taken       = 1'b0;
    int   res_wait       = 0;
    int   res_max_gap    = 5;
    bit   res_taken      = 1'b0;
    bit   hold_request   = 1'b0;
    int   hold_left      = 0;
    int   quiet_cycles   = 0;

    logic [6:0] addr_shadow  = DEV_ADDR_RST;
    logic [7:0] index_shadow = FIRST_REG_RST;
    t_phase     phase_shadow = PH_IDLE;
    logic [3:0] count_shadow = '0;
    logic [7:0] frame_shadow [FRAME_LEN];

    imu_burst_read_sequencer_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (ev_valid),
        .o_ready    (o_ready),
        .i_data     (ev_data),
        .o_valid    (o_valid),
        .i_ready    (res_ready),
        .o_data     (o_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_out sequencer_step(input t_in ev);
        t_out r;
        r = '0;
        case (t_op'(ev.operation))
            OP_BEGIN: begin
                if (phase_shadow == PH_IDLE) r.action = ACT_START;
            end
            OP_START_SENT: begin
                if (phase_shadow == PH_IDLE) begin
                    r.action     = ACT_ADDR_W;
                    r.tx_byte    = {addr_shadow, 1'b0};
                    phase_shadow = PH_ADDR_W;
                end else if (phase_shadow == PH_RESTART) begin
                    r.action     = ACT_ADDR_R;
                    r.tx_byte    = {addr_shadow, 1'b1};
                    phase_shadow = PH_ADDR_R;
                end
            end
            OP_ADDR_ACK: begin
                if (phase_shadow == PH_ADDR_W) begin
                    r.action     = ACT_INDEX;
                    r.tx_byte    = index_shadow;
                    phase_shadow = PH_INDEX;
                end else if (phase_shadow == PH_ADDR_R) begin
                    count_shadow = '0;
                    phase_shadow = PH_DATA;
                end
            end
            default: begin
                if (phase_shadow == PH_INDEX) begin
                    r.action     = ACT_START;
                    phase_shadow = PH_RESTART;
                end else if (phase_shadow == PH_DATA) begin
                    if (count_shadow < FRAME_LEN) frame_shadow[count_shadow] = ev.rx_byte;
                    count_shadow = count_shadow + 4'd1;
                    r.action = (count_shadow >= NACK_FROM) ? ACT_STORED_STOP : ACT_STORED;
                    if (count_shadow >= FRAME_LEN) begin
                        count_shadow   = '0;
                        phase_shadow   = PH_IDLE;
                        r.sample_valid = 1'b1;
                        r.accel_x      = {frame_shadow[0],  frame_shadow[1]};
                        r.accel_y      = {frame_shadow[2],  frame_shadow[3]};
                        r.accel_z      = {frame_shadow[4],  frame_shadow[5]};
                        r.temperature  = {frame_shadow[6],  frame_shadow[7]};
                        r.gyro_x       = {frame_shadow[8],  frame_shadow[9]};
                        r.gyro_y       = {frame_shadow[10], frame_shadow[11]};
                        r.gyro_z       = {frame_shadow[12], frame_shadow[13]};
                    end
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED) $display("%0t: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s: got %h, expected %h", name, got, want));
    endtask

    task automatic compare_result(input t_out got, input t_out want);
        compare_field("action",       16'(got.action),       16'(want.action));
        compare_field("tx_byte",      16'(got.tx_byte),      16'(want.tx_byte));
        compare_field("sample_valid", 16'(got.sample_valid), 16'(want.sample_valid));
        compare_field("accel_x",      got.accel_x,           want.accel_x);
        compare_field("accel_y",      got.accel_y,           want.accel_y);
        compare_field("accel_z",      got.accel_z,           want.accel_z);
        compare_field("temperature",  got.temperature,       want.temperature);
        compare_field("gyro_x",       got.gyro_x,            want.gyro_x);
        compare_field("gyro_y",       got.gyro_y,            want.gyro_y);
        compare_field("gyro_z",       got.gyro_z,            want.gyro_z);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (ev_valid && o_ready) begin
                pending_results.push_back(sequencer_step(ev_data));
                ev_taken = 1'b1;
            end
            if (o_valid && res_ready) begin
                res_taken = 1'b1;
                if (pending_results.size() == 0)
                    report_mismatch("result transaction with nothing expected");
                else
                    compare_result(o_data, pending_results.pop_front());
            end
        end
    end

    always @(negedge i_clk) begin
        bit was_taken;
        was_taken = ev_taken;
        ev_taken  = 1'b0;
        if (was_taken) ev_gap = $urandom_range(0, ev_max_gap);
        if (ev_valid && !was_taken) begin
        end else if (ev_gap > 0) begin
            ev_gap--;
            ev_valid <= 1'b0;
        end else if (queued_events.size() > 0) begin
            ev_data  <= queued_events.pop_front();
            ev_valid <= 1'b1;
        end else begin
            ev_valid <= 1'b0;
        end
    end

    always @(negedge i_clk) begin
        if (res_taken) begin
            res_taken = 1'b0;
            res_wait  = $urandom_range(0, res_max_gap);
        end
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_ready <= 1'b0;
        end else if (res_wait > 0) begin
            res_wait--;
            res_ready <= 1'b0;
        end else begin
            res_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((ev_valid && o_ready) || (o_valid && res_ready) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic push_event(input t_op op, input logic [7:0] rx);
        t_in ev;
        ev.operation = op;
        ev.rx_byte   = rx;
        queued_events.push_back(ev);
        events_queued++;
    endtask

    function automatic t_op sequence_op(input int pos);
        case (pos)
            0:       return OP_BEGIN;
            1, 4:    return OP_START_SENT;
            2, 5:    return OP_ADDR_ACK;
            default: return OP_BYTE_DONE;
        endcase
    endfunction

    task automatic push_sequence(input int first, input int last);
        for (int k = first; k < last; k++) push_event(sequence_op(k), 8'($urandom_range(0, 255)));
    endtask

    task automatic push_noise(input int count);
        logic [1:0] op_bits;
        for (int k = 0; k < count; k++) begin
            op_bits = 2'($urandom_range(0, 3));
            push_event(t_op'(op_bits), 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic wait_idle();
        while (queued_events.size() != 0 || ev_valid || pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_idx idx, input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_DEVICE_ADDRESS) addr_shadow = value[6:0];
        else index_shadow = value;
    endtask

    initial begin
        logic [7:0] frame_pattern [FRAME_LEN];
        int         phase_no;
        int         pick;
        frame_pattern = '{8'h80, 8'h00, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'h00,
                          8'h00, 8'h80, 8'h01, 8'h55, 8'hAA, 8'h01, 8'h80};
        phase_no = 0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // stray idle events, repeated begin, out-of-phase events, a frame
        push_event(OP_BYTE_DONE, 8'hFF);
        push_event(OP_ADDR_ACK, 8'h00);
        push_event(OP_BEGIN, 8'hA5);
        push_event(OP_BEGIN, 8'h5A);
        push_event(OP_START_SENT, 8'h00);
        push_event(OP_BEGIN, 8'hFF);
        push_event(OP_START_SENT, 8'h0F);
        push_event(OP_ADDR_ACK, 8'hF0);
        push_event(OP_BYTE_DONE, 8'h33);
        push_event(OP_START_SENT, 8'hCC);
        push_event(OP_ADDR_ACK, 8'h01);
        foreach (frame_pattern[k]) push_event(OP_BYTE_DONE, frame_pattern[k]);
        wait_idle();

        // reconfigure mid-sequence, before the repeated start
        push_sequence(0, 4);
        wait_idle();
        write_register(CFG_DEVICE_ADDRESS, 8'hFF);
        write_register(CFG_FIRST_REGISTER, 8'h00);
        push_sequence(4, SEQ_LEN);

        while (events_queued < TARGET_EVENTS) begin
            wait_idle();
            case (phase_no)
                0: begin
                    write_register(CFG_DEVICE_ADDRESS, 8'h00);
                    write_register(CFG_FIRST_REGISTER, 8'h00);
                end
                1: begin
                    write_register(CFG_DEVICE_ADDRESS, 8'h7F);
                    write_register(CFG_FIRST_REGISTER, 8'hFF);
                end
                2: begin
                    write_register(CFG_DEVICE_ADDRESS, 8'(DEV_ADDR_RST));
                    write_register(CFG_FIRST_REGISTER, FIRST_REG_RST);
                end
                default: begin
                    if ($urandom_range(0, 3) != 0)
                        write_register(CFG_DEVICE_ADDRESS, 8'($urandom_range(0, 255)));
                    if ($urandom_range(0, 3) != 0)
                        write_register(CFG_FIRST_REGISTER, 8'($urandom_range(0, 255)));
                end
            endcase
            ev_max_gap  = ($urandom_range(0, 2) == 0) ? 0 : 5;
            res_max_gap = ($urandom_range(0, 2) == 0) ? 0 : 5;
            if (phase_no == 3) ev_max_gap = 0;
            repeat (4) begin
                pick = $urandom_range(0, 9);
                if (pick < 7) push_sequence(0, SEQ_LEN);
                else if (pick == 7) push_sequence(0, $urandom_range(1, SEQ_LEN - 1));
                else if (pick == 8) push_sequence($urandom_range(1, SEQ_LEN - 1), SEQ_LEN);
                else push_noise($urandom_range(1, 8));
            end
            if (phase_no == 3) hold_request = 1'b1;
            phase_no++;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/imubrs_pkg.sv
hw/rtl/imubrs_fsm.sv
hw/rtl/imubrs_frame.sv
hw/rtl/imubrs_out_buf.sv
hw/rtl/imu_burst_read_sequencer_top.sv
bench/imu_burst_read_sequencer_top_tb.sv
